FILE: src/cpcr_pkg.sv
// Shared types, constants and helpers for the circle pair collision resolver.
`default_nettype none

package cpcr_pkg;

    // Quotient and root bits produced by the bit-per-stage square root and dividers.
    localparam int STEPS = 31;
    // Front stages (input, difference, squares, overlap test), square root,
    // normal setup, normal division and the seven tail stages.
    localparam int LAT = 4 + STEPS + 1 + STEPS + 7;

    localparam logic [30:0] ONE30 = 31'h4000_0000;
    localparam logic [16:0] RESTITUTION_RST = 17'd65536;
    localparam logic [16:0] RESTITUTION_MAX = 17'd65536;

    // Register byte addresses on the configuration port.
    localparam logic [2:0] ADDR_RESTITUTION = 3'd0;

    typedef struct packed {
        logic signed [31:0] apx;
        logic signed [31:0] apy;
        logic signed [31:0] avx;
        logic signed [31:0] avy;
        logic signed [31:0] bpx;
        logic signed [31:0] bpy;
        logic signed [31:0] bvx;
        logic signed [31:0] bvy;
    } kin_t;

    typedef struct packed {
        kin_t        kin;
        logic [30:0] ad;
        logic [30:0] am;
        logic [30:0] bd;
        logic [30:0] bm;
    } in_t;

    typedef struct packed {
        kin_t               kin;
        logic [31:0]        sx;
        logic               dx_neg;
        logic               dy_neg;
        logic [30:0]        adx;
        logic [30:0]        ady;
        logic [30:0]        bm;
        logic [31:0]        msum;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
        logic               pre;
        logic               zero;
    } fr_t;

    typedef struct packed {
        kin_t               kin;
        logic [31:0]        sx;
        logic               dx_neg;
        logic               dy_neg;
        logic [30:0]        adx;
        logic [30:0]        ady;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
        logic               hit;
        logic               coin;
    } sq_ctx_t;

    typedef struct packed {
        kin_t               kin;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
        logic               dx_neg;
        logic               dy_neg;
        logic               hit;
        logic               coin;
        logic [31:0]        p2;
        logic [30:0]        wa;
        logic [30:0]        wb;
    } dv_ctx_t;

    typedef struct packed {
        kin_t               kin;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
        logic               hit;
        logic               coin;
        logic [30:0]        wa;
        logic [30:0]        wb;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic               sep;
        logic signed [31:0] pax;
        logic signed [31:0] pay;
        logic signed [31:0] pbx;
        logic signed [31:0] pby;
    } tail_t;

    typedef struct packed {
        logic [2:0]   user;
        logic [255:0] data;
    } out_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -40'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [30:0] mag31(input logic signed [31:0] v);
        logic [31:0] m;
        m = v[31] ? 32'(-v) : 32'(v);
        return m[30:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/circle_pair_collision_resolve_top.sv
// Top level of the circle pair collision resolver: stream ports, register port and pipeline.
`default_nettype none

// Resolves one pair of circles per transfer and accepts a new pair on every
// clock cycle while the skid entry is free. Each pair passes two chains of
// 31 single-bit stages: the square root of the squared center distance (which
// runs beside the inverse-mass weight divider), followed by the two dividers
// that form the unit normal. After that a result sits in an output register,
// with one skid entry behind it, so m_tready is never in a combinational path
// to s_tready. A pair that does not overlap comes out unchanged with all flags
// low. A pair whose centers coincide is flagged coincident and left unchanged.
// An overlapping pair is pushed apart along the center line, the overlap
// shared by inverse mass, and if the circles approach each other both
// velocities receive an impulse scaled by one plus the restitution register;
// if they already move apart, separating is set and velocities are kept. All
// new values saturate to the signed 32-bit range. The restitution register
// (Q1.16, reset to 1.0, values above 1.0 act as 1.0) should be written only
// while no pair is in flight.
module circle_pair_collision_resolve_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Input pairs.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // a_pos_x, a_pos_y, a_vel_x, a_vel_y (32 each), a_diameter, a_mass (31 each),
    // b_pos_x, b_pos_y, b_vel_x, b_vel_y (32 each), b_diameter, b_mass (31 each),
    // then four zero bits.
    input  wire logic [383:0] s_tdata,
    // Resolved pairs.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y,
    // new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y (32 bits each).
    output logic      [255:0] m_tdata,
    // overlapped, coincident, separating.
    output logic      [2:0]   m_tuser,
    // Register port.
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);
    import cpcr_pkg::*;

    // ------------------------------------------------------------------
    // Register port.
    // ------------------------------------------------------------------
    logic [16:0] restitution_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            restitution_reg <= RESTITUTION_RST;
        else if (psel && penable && pwrite && paddr == ADDR_RESTITUTION)
            restitution_reg <= pwdata[16:0];
    end

    assign prdata = (paddr == ADDR_RESTITUTION) ? {15'd0, restitution_reg} : 32'd0;

    // ------------------------------------------------------------------
    // Flow control. The whole pipeline moves together while the skid entry
    // is free; the skid entry absorbs the one result that may arrive in the
    // cycle in which the output register stalls.
    // ------------------------------------------------------------------
    logic             adv;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    out_t             out_reg;
    out_t             skid_reg;
    out_t             e7_reg;
    logic [LAT-1:0]   vld_reg;

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    // ------------------------------------------------------------------
    // Stage 0: capture the input transfer.
    // ------------------------------------------------------------------
    in_t in_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_reg.kin.apx <= s_tdata[31:0];
            in_reg.kin.apy <= s_tdata[63:32];
            in_reg.kin.avx <= s_tdata[95:64];
            in_reg.kin.avy <= s_tdata[127:96];
            in_reg.ad      <= s_tdata[158:128];
            in_reg.am      <= s_tdata[189:159];
            in_reg.kin.bpx <= s_tdata[221:190];
            in_reg.kin.bpy <= s_tdata[253:222];
            in_reg.kin.bvx <= s_tdata[285:254];
            in_reg.kin.bvy <= s_tdata[317:286];
            in_reg.bd      <= s_tdata[348:318];
            in_reg.bm      <= s_tdata[379:349];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: center difference, relative velocity, diameter and mass sums.
    // A zero mass counts as the smallest nonzero mass.
    // ------------------------------------------------------------------
    fr_t s1_next;
    fr_t s1_reg;

    always_comb
    begin
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [32:0]        adx;
        logic [32:0]        ady;
        logic [30:0]        am1;
        logic [30:0]        bm1;
        dx  = 33'(in_reg.kin.apx) - 33'(in_reg.kin.bpx);
        dy  = 33'(in_reg.kin.apy) - 33'(in_reg.kin.bpy);
        adx = dx[32] ? 33'(-dx) : 33'(dx);
        ady = dy[32] ? 33'(-dy) : 33'(dy);
        am1 = (in_reg.am == '0) ? 31'd1 : in_reg.am;
        bm1 = (in_reg.bm == '0) ? 31'd1 : in_reg.bm;
        s1_next.kin    = in_reg.kin;
        s1_next.sx     = 32'(in_reg.ad) + 32'(in_reg.bd);
        s1_next.dx_neg = dx[32];
        s1_next.dy_neg = dy[32];
        s1_next.adx    = adx[30:0];
        s1_next.ady    = ady[30:0];
        s1_next.bm     = bm1;
        s1_next.msum   = 32'(am1) + 32'(bm1);
        s1_next.rvx    = 33'(in_reg.kin.avx) - 33'(in_reg.kin.bvx);
        s1_next.rvy    = 33'(in_reg.kin.avy) - 33'(in_reg.kin.bvy);
        // Both axis distances must be under the radius sum before the squared
        // test can be trusted to stay in range.
        s1_next.pre    = ({adx, 1'b0} < {2'b00, s1_next.sx})
                      && ({ady, 1'b0} < {2'b00, s1_next.sx});
        s1_next.zero   = (adx == '0) && (ady == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s1_reg <= s1_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: squares of the axis distances and of the diameter sum.
    // ------------------------------------------------------------------
    fr_t         s2_reg;
    logic [61:0] a2_reg;
    logic [61:0] b2_reg;
    logic [63:0] ss_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg <= s1_reg;
            a2_reg <= 62'(s1_reg.adx) * 62'(s1_reg.adx);
            b2_reg <= 62'(s1_reg.ady) * 62'(s1_reg.ady);
            ss_reg <= 64'(s1_reg.sx) * 64'(s1_reg.sx);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: overlap test, 4*(dx^2 + dy^2) strictly below (da + db)^2.
    // ------------------------------------------------------------------
    fr_t         s3_reg;
    logic        hit3_reg;
    logic        coin3_reg;
    logic [61:0] sq3_reg;
    logic        hit3_next;

    assign hit3_next = s2_reg.pre && ({a2_reg, 2'b00} < (ss_reg - {b2_reg, 2'b00}));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_reg    <= s2_reg;
            hit3_reg  <= hit3_next;
            coin3_reg <= hit3_next && s2_reg.zero;
            sq3_reg   <= a2_reg + b2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Center distance and mass weight, computed side by side.
    // ------------------------------------------------------------------
    logic [30:0] ctr_dist;
    logic [30:0] wa_q;
    sq_ctx_t     dl_reg [STEPS];
    sq_ctx_t     dl_next;

    cpcr_sqrt_pipe u_sqrt (
        .clk      (clk),
        .adv      (adv),
        .radicand (sq3_reg),
        .root     (ctr_dist)
    );

    cpcr_div_pipe u_div_w (
        .clk (clk),
        .adv (adv),
        .num ({1'b0, s3_reg.bm, 30'd0}),
        .den (s3_reg.msum),
        .quo (wa_q)
    );

    always_comb
    begin
        dl_next.kin    = s3_reg.kin;
        dl_next.sx     = s3_reg.sx;
        dl_next.dx_neg = s3_reg.dx_neg;
        dl_next.dy_neg = s3_reg.dy_neg;
        dl_next.adx    = s3_reg.adx;
        dl_next.ady    = s3_reg.ady;
        dl_next.rvx    = s3_reg.rvx;
        dl_next.rvy    = s3_reg.rvy;
        dl_next.hit    = hit3_reg;
        dl_next.coin   = coin3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dl_reg[0] <= dl_next;
            for (int k = 1; k < STEPS; k++)
                dl_reg[k] <= dl_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Normal setup: overlap in half units, weights for both circles.
    // ------------------------------------------------------------------
    dv_ctx_t     p_next;
    dv_ctx_t     p_reg;
    logic [30:0] padx_reg;
    logic [30:0] pady_reg;
    logic [30:0] pd_reg;

    always_comb
    begin
        p_next.kin    = dl_reg[STEPS-1].kin;
        p_next.rvx    = dl_reg[STEPS-1].rvx;
        p_next.rvy    = dl_reg[STEPS-1].rvy;
        p_next.dx_neg = dl_reg[STEPS-1].dx_neg;
        p_next.dy_neg = dl_reg[STEPS-1].dy_neg;
        p_next.hit    = dl_reg[STEPS-1].hit;
        p_next.coin   = dl_reg[STEPS-1].coin;
        p_next.p2     = dl_reg[STEPS-1].sx - {ctr_dist, 1'b0};
        p_next.wa     = wa_q;
        p_next.wb     = ONE30 - wa_q;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg    <= p_next;
            padx_reg <= dl_reg[STEPS-1].adx;
            pady_reg <= dl_reg[STEPS-1].ady;
            pd_reg   <= ctr_dist;
        end
    end

    // ------------------------------------------------------------------
    // Unit normal magnitudes, |dx| * 2^30 / d and |dy| * 2^30 / d.
    // ------------------------------------------------------------------
    logic [30:0] nqx;
    logic [30:0] nqy;
    dv_ctx_t     dv_reg [STEPS];

    cpcr_div_pipe u_div_x (
        .clk (clk),
        .adv (adv),
        .num ({1'b0, padx_reg, 30'd0}),
        .den ({1'b0, pd_reg}),
        .quo (nqx)
    );

    cpcr_div_pipe u_div_y (
        .clk (clk),
        .adv (adv),
        .num ({1'b0, pady_reg, 30'd0}),
        .den ({1'b0, pd_reg}),
        .quo (nqy)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0] <= p_reg;
            for (int k = 1; k < STEPS; k++)
                dv_reg[k] <= dv_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Tail stage 1: signed normal, push lengths for both circles.
    // ------------------------------------------------------------------
    tail_t       t1_next;
    tail_t       t1_reg;
    logic [31:0] pa1_reg;
    logic [31:0] pb1_reg;
    logic [62:0] pa_prod;
    logic [62:0] pb_prod;

    always_comb
    begin
        dv_ctx_t c;
        c = dv_reg[STEPS-1];
        t1_next.kin  = c.kin;
        t1_next.rvx  = c.rvx;
        t1_next.rvy  = c.rvy;
        t1_next.hit  = c.hit;
        t1_next.coin = c.coin;
        t1_next.wa   = c.wa;
        t1_next.wb   = c.wb;
        t1_next.nx   = c.dx_neg ? 32'(-{1'b0, nqx}) : {1'b0, nqx};
        t1_next.ny   = c.dy_neg ? 32'(-{1'b0, nqy}) : {1'b0, nqy};
        t1_next.sep  = 1'b0;
        t1_next.pax  = c.kin.apx;
        t1_next.pay  = c.kin.apy;
        t1_next.pbx  = c.kin.bpx;
        t1_next.pby  = c.kin.bpy;
        pa_prod      = 63'(c.p2) * 63'(c.wa);
        pb_prod      = 63'(c.p2) * 63'(c.wb);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg  <= t1_next;
            pa1_reg <= pa_prod[62:31];
            pb1_reg <= pb_prod[62:31];
        end
    end

    // ------------------------------------------------------------------
    // Tail stage 2: normal speed products and push vectors.
    // ------------------------------------------------------------------
    tail_t              t2_reg;
    logic signed [64:0] px_reg;
    logic signed [64:0] py_reg;
    logic signed [33:0] dax_reg;
    logic signed [33:0] day_reg;
    logic signed [33:0] dbx_reg;
    logic signed [33:0] dby_reg;
    logic signed [33:0] dax_next;
    logic signed [33:0] day_next;
    logic signed [33:0] dbx_next;
    logic signed [33:0] dby_next;

    always_comb
    begin
        logic [30:0] nmx;
        logic [30:0] nmy;
        logic [62:0] m_ax;
        logic [62:0] m_ay;
        logic [62:0] m_bx;
        logic [62:0] m_by;
        nmx  = mag31(t1_reg.nx);
        nmy  = mag31(t1_reg.ny);
        m_ax = 63'(pa1_reg) * 63'(nmx);
        m_ay = 63'(pa1_reg) * 63'(nmy);
        m_bx = 63'(pb1_reg) * 63'(nmx);
        m_by = 63'(pb1_reg) * 63'(nmy);
        dax_next = t1_reg.nx[31] ? 34'(-{1'b0, m_ax[62:30]}) : 34'({1'b0, m_ax[62:30]});
        day_next = t1_reg.ny[31] ? 34'(-{1'b0, m_ay[62:30]}) : 34'({1'b0, m_ay[62:30]});
        dbx_next = t1_reg.nx[31] ? 34'(-{1'b0, m_bx[62:30]}) : 34'({1'b0, m_bx[62:30]});
        dby_next = t1_reg.ny[31] ? 34'(-{1'b0, m_by[62:30]}) : 34'({1'b0, m_by[62:30]});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t2_reg  <= t1_reg;
            px_reg  <= 65'(t1_reg.rvx) * 65'(t1_reg.nx);
            py_reg  <= 65'(t1_reg.rvy) * 65'(t1_reg.ny);
            dax_reg <= dax_next;
            day_reg <= day_next;
            dbx_reg <= dbx_next;
            dby_reg <= dby_next;
        end
    end

    // ------------------------------------------------------------------
    // Tail stage 3: normal speed, separation test, pushed positions.
    // ------------------------------------------------------------------
    tail_t       t3_next;
    tail_t       t3_reg;
    logic [32:0] kk_reg;
    logic [32:0] kk_next;

    always_comb
    begin
        logic signed [64:0] dot;
        logic [64:0]        adot;
        dot  = px_reg + py_reg;
        adot = dot[64] ? 65'(-dot) : 65'(dot);
        kk_next = adot[62:30];
        t3_next     = t2_reg;
        t3_next.sep = !dot[64] && (dot != '0);
        t3_next.pax = sat32(40'(t2_reg.kin.apx) + 40'(dax_reg));
        t3_next.pay = sat32(40'(t2_reg.kin.apy) + 40'(day_reg));
        t3_next.pbx = sat32(40'(t2_reg.kin.bpx) - 40'(dbx_reg));
        t3_next.pby = sat32(40'(t2_reg.kin.bpy) - 40'(dby_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t3_reg <= t3_next;
            kk_reg <= kk_next;
        end
    end

    // ------------------------------------------------------------------
    // Tail stage 4: impulse magnitude, scaled by one plus restitution.
    // ------------------------------------------------------------------
    tail_t       t4_reg;
    logic [33:0] q_reg;
    logic [49:0] q_prod;

    always_comb
    begin
        logic [16:0] e;
        e      = (restitution_reg > RESTITUTION_MAX) ? RESTITUTION_MAX : restitution_reg;
        q_prod = 50'(kk_reg) * (50'(RESTITUTION_MAX) + 50'(e));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t4_reg <= t3_reg;
            q_reg  <= q_prod[49:16];
        end
    end

    // ------------------------------------------------------------------
    // Tail stage 5: impulse shares by inverse mass.
    // ------------------------------------------------------------------
    tail_t       t5_reg;
    logic [33:0] qa_reg;
    logic [33:0] qb_reg;
    logic [64:0] qa_prod;
    logic [64:0] qb_prod;

    assign qa_prod = 65'(q_reg) * 65'(t4_reg.wa);
    assign qb_prod = 65'(q_reg) * 65'(t4_reg.wb);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t5_reg <= t4_reg;
            qa_reg <= qa_prod[63:30];
            qb_reg <= qb_prod[63:30];
        end
    end

    // ------------------------------------------------------------------
    // Tail stage 6: velocity changes along the normal.
    // ------------------------------------------------------------------
    tail_t              t6_reg;
    logic signed [34:0] wax_reg;
    logic signed [34:0] way_reg;
    logic signed [34:0] wbx_reg;
    logic signed [34:0] wby_reg;
    logic signed [34:0] wax_next;
    logic signed [34:0] way_next;
    logic signed [34:0] wbx_next;
    logic signed [34:0] wby_next;

    always_comb
    begin
        logic [30:0] nmx;
        logic [30:0] nmy;
        logic [64:0] m_ax;
        logic [64:0] m_ay;
        logic [64:0] m_bx;
        logic [64:0] m_by;
        nmx  = mag31(t5_reg.nx);
        nmy  = mag31(t5_reg.ny);
        m_ax = 65'(qa_reg) * 65'(nmx);
        m_ay = 65'(qa_reg) * 65'(nmy);
        m_bx = 65'(qb_reg) * 65'(nmx);
        m_by = 65'(qb_reg) * 65'(nmy);
        wax_next = t5_reg.nx[31] ? 35'(-{1'b0, m_ax[63:30]}) : 35'({1'b0, m_ax[63:30]});
        way_next = t5_reg.ny[31] ? 35'(-{1'b0, m_ay[63:30]}) : 35'({1'b0, m_ay[63:30]});
        wbx_next = t5_reg.nx[31] ? 35'(-{1'b0, m_bx[63:30]}) : 35'({1'b0, m_bx[63:30]});
        wby_next = t5_reg.ny[31] ? 35'(-{1'b0, m_by[63:30]}) : 35'({1'b0, m_by[63:30]});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t6_reg  <= t5_reg;
            wax_reg <= wax_next;
            way_reg <= way_next;
            wbx_reg <= wbx_next;
            wby_reg <= wby_next;
        end
    end

    // ------------------------------------------------------------------
    // Tail stage 7: new velocities and selection of the result.
    // ------------------------------------------------------------------
    out_t e7_next;

    always_comb
    begin
        kin_t r;
        logic resolved;
        resolved = t6_reg.hit && !t6_reg.coin;
        r = t6_reg.kin;
        if (resolved)
        begin
            r.apx = t6_reg.pax;
            r.apy = t6_reg.pay;
            r.bpx = t6_reg.pbx;
            r.bpy = t6_reg.pby;
            if (!t6_reg.sep)
            begin
                r.avx = sat32(40'(t6_reg.kin.avx) + 40'(wax_reg));
                r.avy = sat32(40'(t6_reg.kin.avy) + 40'(way_reg));
                r.bvx = sat32(40'(t6_reg.kin.bvx) - 40'(wbx_reg));
                r.bvy = sat32(40'(t6_reg.kin.bvy) - 40'(wby_reg));
            end
        end
        e7_next.data = {r.bvy, r.bvx, r.bpy, r.bpx, r.avy, r.avx, r.apy, r.apx};
        e7_next.user = {resolved && t6_reg.sep, t6_reg.coin, resolved};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            e7_reg <= e7_next;
    end

    // ------------------------------------------------------------------
    // Output register and skid entry.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (vld_reg[LAT-1])
            begin
                if (!out_valid_reg || m_tready)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (m_tready)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (vld_reg[LAT-1])
            begin
                if (!out_valid_reg || m_tready)
                    out_reg <= e7_reg;
                else
                    skid_reg <= e7_reg;
            end
        end
        else if (m_tready)
        begin
            out_reg <= skid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = out_reg.user;

endmodule

`default_nettype wire

FILE: src/cpcr_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module cpcr_sqrt_pipe (
    input  wire logic        clk,
    input  wire logic        adv,
    input  wire logic [61:0] radicand,
    output logic      [30:0] root
);
    import cpcr_pkg::*;

    logic [61:0] v_in   [STEPS];
    logic [61:0] r_in   [STEPS];
    logic [61:0] v_next [STEPS];
    logic [61:0] r_next [STEPS];
    logic [61:0] v_reg  [STEPS];
    logic [61:0] r_reg  [STEPS];

    genvar j;
    for (j = 0; j < STEPS; j++)
    begin : g_st
        localparam int SH = 2 * (STEPS - 1 - j);
        localparam logic [61:0] BITV = 62'(1) << SH;

        if (j == 0)
        begin : g_first
            assign v_in[j] = radicand;
            assign r_in[j] = '0;
        end
        else
        begin : g_rest
            assign v_in[j] = v_reg[j-1];
            assign r_in[j] = r_reg[j-1];
        end

        always_comb
        begin
            logic [61:0] trial;
            trial = r_in[j] + BITV;
            if (v_in[j] >= trial)
            begin
                v_next[j] = v_in[j] - trial;
                r_next[j] = (r_in[j] >> 1) + BITV;
            end
            else
            begin
                v_next[j] = v_in[j];
                r_next[j] = r_in[j] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                v_reg[j] <= v_next[j];
                r_reg[j] <= r_next[j];
            end
        end
    end

    assign root = r_reg[STEPS-1][30:0];

endmodule

`default_nettype wire

FILE: src/cpcr_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module cpcr_div_pipe (
    input  wire logic        clk,
    input  wire logic        adv,
    input  wire logic [61:0] num,
    input  wire logic [31:0] den,
    output logic      [30:0] quo
);
    import cpcr_pkg::*;

    // The quotient is known to fit in 31 bits, so the upper dividend bits
    // start out as the partial remainder.
    logic [31:0] rem_in   [STEPS];
    logic [31:0] den_in   [STEPS];
    logic [30:0] lo_in    [STEPS];
    logic [30:0] q_in     [STEPS];
    logic [31:0] rem_next [STEPS];
    logic [30:0] q_next   [STEPS];
    logic [31:0] rem_reg  [STEPS];
    logic [31:0] den_reg  [STEPS];
    logic [30:0] lo_reg   [STEPS];
    logic [30:0] q_reg    [STEPS];

    genvar j;
    for (j = 0; j < STEPS; j++)
    begin : g_st
        localparam int BI = STEPS - 1 - j;

        if (j == 0)
        begin : g_first
            assign rem_in[j] = {1'b0, num[61:31]};
            assign den_in[j] = den;
            assign lo_in[j]  = num[30:0];
            assign q_in[j]   = '0;
        end
        else
        begin : g_rest
            assign rem_in[j] = rem_reg[j-1];
            assign den_in[j] = den_reg[j-1];
            assign lo_in[j]  = lo_reg[j-1];
            assign q_in[j]   = q_reg[j-1];
        end

        always_comb
        begin
            logic [32:0] r2;
            r2 = {rem_in[j], lo_in[j][BI]};
            if (r2 >= {1'b0, den_in[j]})
            begin
                rem_next[j] = 32'(r2 - {1'b0, den_in[j]});
                q_next[j]   = {q_in[j][29:0], 1'b1};
            end
            else
            begin
                rem_next[j] = r2[31:0];
                q_next[j]   = {q_in[j][29:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j] <= rem_next[j];
                den_reg[j] <= den_in[j];
                lo_reg[j]  <= lo_in[j];
                q_reg[j]   <= q_next[j];
            end
        end
    end

    assign quo = q_reg[STEPS-1];

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the circle pair collision resolver.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpcr_pkg::*;

    // One circle pair as it travels on the input stream.
    typedef struct {
        logic signed [31:0] apx, apy, avx, avy;
        logic        [30:0] ad, am;
        logic signed [31:0] bpx, bpy, bvx, bvy;
        logic        [30:0] bd, bm;
    } pair_t;

    // One resolved pair as it travels on the output stream.
    typedef struct packed {
        logic [2:0]   flags;
        logic [255:0] kin;
    } resolved_t;

    typedef enum int { PK_NOISE, PK_CLOSE, PK_COIN, PK_EXTREME } pair_kind_t;

    localparam logic [63:0] UNIT30 = 64'd1 << 30;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [383:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [255:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    circle_pair_collision_resolve_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Pairs waiting to be offered, and resolved pairs still owed by the block.
    pair_t     pending_pairs[$];
    resolved_t owed_results[$];

    // Our copy of the restitution register.
    logic [16:0] bounce;
    int          fails;
    int          send_idle;
    int          recv_idle;
    logic        hold_go;
    int          hold_cnt;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Generous limit well above the slowest correct run.
    initial begin
        #4_000_000;
        $display("circle_pair_collision_resolve_top: mismatch");
        $finish;
    end

    // Appends a pair to the queue of pairs waiting to be offered.
    function automatic void queue_pair(pair_t p);
        pending_pairs = {pending_pairs, p};
    endfunction

    function automatic logic [63:0] umag(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Magnitude times a Q1.30 direction, truncated toward zero.
    function automatic longint along(logic [63:0] mag, longint n);
        logic [63:0] p;
        p = (mag * umag(n)) >> 30;
        return n < 0 ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Predicts the resolved pair: overlap test, push along the normal, impulse.
    function automatic resolved_t resolve_pair(pair_t p);
        longint      apx, apy, avx, avy, bpx, bpy, bvx, bvy;
        longint      dx, dy, nx, ny, rvx, rvy, dot;
        logic [63:0] adx, ady, sx, ma, mb, d, p2, wa, wb, pa, pb, e, kk, q, qa, qb;
        logic [31:0] r[8];
        logic        hit, ovl, coin, sep;
        resolved_t   res;
        apx = p.apx; apy = p.apy; avx = p.avx; avy = p.avy;
        bpx = p.bpx; bpy = p.bpy; bvx = p.bvx; bvy = p.bvy;
        r[0] = p.apx; r[1] = p.apy; r[2] = p.avx; r[3] = p.avy;
        r[4] = p.bpx; r[5] = p.bpy; r[6] = p.bvx; r[7] = p.bvy;
        ma = (p.am == 0) ? 64'd1 : 64'(p.am);
        mb = (p.bm == 0) ? 64'd1 : 64'(p.bm);
        dx = apx - bpx;
        dy = apy - bpy;
        adx = umag(dx);
        ady = umag(dy);
        sx = 64'(p.ad) + 64'(p.bd);
        hit = 1'b0;
        ovl = 1'b0;
        coin = 1'b0;
        sep = 1'b0;
        if (2 * adx < sx && 2 * ady < sx)
            hit = (4 * adx * adx) < (sx * sx - 4 * ady * ady);
        if (hit && adx == 0 && ady == 0) begin
            coin = 1'b1;
        end else if (hit) begin
            d = int_sqrt(adx * adx + ady * ady);
            nx = (dx * longint'(UNIT30)) / longint'(d);
            ny = (dy * longint'(UNIT30)) / longint'(d);
            p2 = sx - 2 * d;
            wa = (mb << 30) / (ma + mb);
            wb = UNIT30 - wa;
            pa = (p2 * wa) >> 31;
            pb = (p2 * wb) >> 31;
            ovl = 1'b1;
            r[0] = clip32(apx + along(pa, nx));
            r[1] = clip32(apy + along(pa, ny));
            r[4] = clip32(bpx - along(pb, nx));
            r[5] = clip32(bpy - along(pb, ny));
            rvx = avx - bvx;
            rvy = avy - bvy;
            dot = rvx * nx + rvy * ny;
            if (dot > 0) begin
                sep = 1'b1;
            end else begin
                e = (bounce > 17'd65536) ? 64'd65536 : 64'(bounce);
                kk = umag(dot) >> 30;
                q = (kk * (64'd65536 + e)) >> 16;
                qa = (q * wa) >> 30;
                qb = (q * wb) >> 30;
                r[2] = clip32(avx + along(qa, nx));
                r[3] = clip32(avy + along(qa, ny));
                r[6] = clip32(bvx - along(qb, nx));
                r[7] = clip32(bvy - along(qb, ny));
            end
        end
        res.flags = {sep, coin, ovl};
        res.kin = {r[7], r[6], r[5], r[4], r[3], r[2], r[1], r[0]};
        return res;
    endfunction

    function automatic logic [383:0] pack_pair(pair_t p);
        return {4'b0, p.bm, p.bd, p.bvy, p.bvx, p.bpy, p.bpx,
                p.am, p.ad, p.avy, p.avx, p.apy, p.apx};
    endfunction

    function automatic logic [30:0] rand_width31();
        return 31'($urandom) >> $urandom_range(30, 0);
    endfunction

    // Builds a pair. Close pairs keep each axis offset of the centers within the
    // radius sum so that most of them overlap and reach the push and impulse logic.
    function automatic pair_t make_pair(pair_kind_t kind);
        pair_t       p;
        int unsigned sz;
        logic [31:0] reach;
        logic [31:0] offx, offy;
        p.apx = $urandom; p.apy = $urandom; p.avx = $urandom; p.avy = $urandom;
        p.bpx = $urandom; p.bpy = $urandom; p.bvx = $urandom; p.bvy = $urandom;
        p.ad = 31'($urandom); p.am = 31'($urandom);
        p.bd = 31'($urandom); p.bm = 31'($urandom);
        if (kind == PK_NOISE) return p;
        sz = $urandom_range(30, 4);
        p.ad = 31'($urandom) & ((31'd1 << sz) - 1);
        p.bd = 31'($urandom) & ((31'd1 << sz) - 1);
        p.am = rand_width31();
        p.bm = rand_width31();
        if ($urandom_range(15) == 0) p.am = 0;
        if ($urandom_range(15) == 0) p.bm = 0;
        if ($urandom_range(1)) begin
            p.avx = $signed(p.avx) >>> $urandom_range(31, 0);
            p.avy = $signed(p.avy) >>> $urandom_range(31, 0);
            p.bvx = $signed(p.bvx) >>> $urandom_range(31, 0);
            p.bvy = $signed(p.bvy) >>> $urandom_range(31, 0);
        end
        reach = (32'(p.ad) + 32'(p.bd)) >> 1;
        offx = $urandom_range(reach, 0);
        offy = $urandom_range(reach, 0);
        if (kind == PK_COIN) begin
            offx = 0;
            offy = 0;
        end
        if (kind == PK_EXTREME) begin
            // Centers near the edge of the range so that pushes saturate.
            p.bpx = $urandom_range(1) ? 32'h7FFF_FFF0 : 32'h8000_0010;
            p.bpy = $urandom_range(1) ? 32'h7FFF_FFF0 : 32'h8000_0010;
        end
        p.apx = p.bpx + ($urandom_range(1) ? offx : -offx);
        p.apy = p.bpy + ($urandom_range(1) ? offy : -offy);
        return p;
    endfunction

    // Stream driver: offers the pending pairs, idling at random.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle) begin
                s_tdata <= pack_pair(pending_pairs[0]);
                owed_results = {owed_results, resolve_pair(pending_pairs[0])};
                void'(pending_pairs.pop_front());
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (hold_go)
            hold_cnt <= 400;
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle);
    end

    // Result monitor: every transfer is checked against the oldest prediction.
    always @(posedge clk) begin
        resolved_t   want;
        string       field_names[8];
        logic [31:0] got_f, want_f;
        field_names = '{"new_a_pos_x", "new_a_pos_y", "new_a_vel_x", "new_a_vel_y",
                        "new_b_pos_x", "new_b_pos_y", "new_b_vel_x", "new_b_vel_y"};
        if (rst_n && m_tvalid && m_tready) begin
            if (owed_results.size() == 0) begin
                $error("result transfer with no pair outstanding");
                fails++;
            end else begin
                want = owed_results.pop_front();
                if (m_tuser[0] !== want.flags[0]) begin
                    $error("overlapped: expected %0d, got %0d", want.flags[0], m_tuser[0]);
                    fails++;
                end
                if (m_tuser[1] !== want.flags[1]) begin
                    $error("coincident: expected %0d, got %0d", want.flags[1], m_tuser[1]);
                    fails++;
                end
                if (m_tuser[2] !== want.flags[2]) begin
                    $error("separating: expected %0d, got %0d", want.flags[2], m_tuser[2]);
                    fails++;
                end
                for (int i = 0; i < 8; i++) begin
                    got_f = m_tdata[32*i +: 32];
                    want_f = want.kin[32*i +: 32];
                    if (got_f !== want_f) begin
                        $error("%s: expected %0d, got %0d", field_names[i],
                               $signed(want_f), $signed(got_f));
                        fails++;
                    end
                end
            end
        end
    end

    // Register write: setup cycle, then access cycle.
    task automatic write_bounce(logic [16:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_RESTITUTION;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        bounce = value;
    endtask

    // Waits until every pair has been offered, accepted and answered.
    task automatic drain();
        while (pending_pairs.size() > 0 || (s_tvalid && !s_tready) || owed_results.size() > 0)
            @(posedge clk);
        repeat (LAT + 10) @(posedge clk);
    endtask

    initial begin
        logic [16:0] bounce_set[6];
        pair_t       p;
        bounce_set = '{17'd0, 17'd65536, 17'd131071, 17'd32768, 17'd1, 17'd65537};
        fails = 0;
        bounce = RESTITUTION_RST;
        send_idle = 36;
        recv_idle = 64;
        hold_go = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed pairs at the reset restitution.
        p = make_pair(PK_NOISE);
        p.apx = 0; p.apy = 0; p.bpx = 0; p.bpy = 32'd200;
        p.ad = 0; p.bd = 0;
        queue_pair(p);                                 // far apart, zero size
        p = make_pair(PK_COIN);
        queue_pair(p);                                 // coincident centers
        p.ad = 31'h7FFF_FFFF; p.bd = 31'h7FFF_FFFF;
        p.apx = 32'h7FFF_FFFF; p.bpx = 32'h8000_0000;
        p.apy = 32'h8000_0000; p.bpy = 32'h7FFF_FFFF;
        queue_pair(p);                                 // largest diameters, far corners
        p = make_pair(PK_CLOSE);
        p.apx = 32'h0001_0000; p.apy = 0; p.bpx = 0; p.bpy = 0;
        p.ad = 31'h0004_0000; p.bd = 31'h0004_0000;
        p.avx = 32'h0002_0000; p.bvx = 0; p.avy = 0; p.bvy = 0;
        queue_pair(p);                                 // moving apart
        p.avx = 32'hFFFE_0000;
        queue_pair(p);                                 // approaching head on
        p.am = 0; p.bm = 0;
        queue_pair(p);                                 // zero masses
        p.am = 31'h7FFF_FFFF; p.bm = 31'd1;
        queue_pair(p);                                 // extreme mass ratio
        p.avx = 32'h8000_0000; p.bvx = 32'h7FFF_FFFF;
        p.avy = 32'h8000_0000; p.bvy = 32'h7FFF_FFFF;
        queue_pair(p);                                 // velocity saturation
        for (int i = 0; i < 12; i++)
            queue_pair(make_pair(pair_kind_t'(i % 4)));
        drain();

        // Random phases, each at a new restitution and one of three idle patterns.
        for (int ph = 0; ph < 8; ph++) begin
            write_bounce(ph < 6 ? bounce_set[ph] : 17'($urandom_range(131071)));
            send_idle = (ph % 3 == 0) ? 36 : (ph % 3 == 1) ? 64 : 0;
            recv_idle = (ph % 3 == 0) ? 64 : (ph % 3 == 1) ? 36 : 0;
            for (int i = 0; i < 48; i++) begin
                case ($urandom_range(9))
                    0, 1:    queue_pair(make_pair(PK_NOISE));
                    2:       queue_pair(make_pair(PK_COIN));
                    3:       queue_pair(make_pair(PK_EXTREME));
                    default: queue_pair(make_pair(PK_CLOSE));
                endcase
            end
            if (ph == 2) begin
                // Stall the output long enough for the pipeline to fill up.
                @(posedge clk);
                hold_go <= 1'b1;
                @(posedge clk);
                hold_go <= 1'b0;
            end
            drain();
        end

        if (fails == 0)
            $display("circle_pair_collision_resolve_top: match");
        else
            $display("circle_pair_collision_resolve_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
src/cpcr_pkg.sv
src/cpcr_sqrt_pipe.sv
src/cpcr_div_pipe.sv
src/circle_pair_collision_resolve_top.sv
tb/tb.sv
